// ----- hw/rtl/ciu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ciu_pkg
// Shared widths, constants and beat types of the circular interval union.
// ----------------------------------------------------------------------------
package ciu_pkg;

  localparam int unsigned TURN_BITS       = 16;
  localparam int unsigned INPUT_TURN_BITS = 3;
  localparam int unsigned IN_W            = TURN_BITS + INPUT_TURN_BITS + 1;
  localparam int unsigned HI_W            = TURN_BITS + 1;

  localparam logic [HI_W-1:0] TURN_HI = HI_W'(1) << TURN_BITS;

  typedef struct packed {
    logic signed [IN_W-1:0] lower_a;
    logic signed [IN_W-1:0] upper_a;
    logic signed [IN_W-1:0] lower_b;
    logic signed [IN_W-1:0] upper_b;
  } ciu_in_t;

  typedef struct packed {
    logic [TURN_BITS-1:0] lower_a_out;
    logic [HI_W-1:0]      upper_a_out;
    logic [TURN_BITS-1:0] lower_b_out;
    logic [HI_W-1:0]      upper_b_out;
  } ciu_out_t;

endpackage

// ----- hw/rtl/circular_interval_union.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_interval_union
// Merges two angular intervals on the circle into one result beat.
// ----------------------------------------------------------------------------
// The block takes one input beat in every clock cycle and never raises busy.
// Each result appears on res_o with done_o high after its input beat has
// passed through four register stages, in the order of the inputs. done_o
// is high for exactly one cycle per result and there is no way to hold
// results off, so the receiver must take each beat in the cycle in which it
// appears. The four register stages are: angle reduction and full-turn
// checks, the ordered containment and overlap flags, the bound selection,
// and the wrap correction with clamping into the output register.
module circular_interval_union (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ciu_pkg::ciu_in_t in_i,
  output logic             done_o,
  output ciu_pkg::ciu_out_t res_o
);
  import ciu_pkg::*;

  localparam logic signed [IN_W:0] TurnWide = (IN_W + 1)'(TURN_HI);

  // Stage 1 signals.
  logic                    acc;
  logic signed [IN_W:0]    dab, dcd;
  logic                    v1_q;
  logic [TURN_BITS-1:0]    a1_q, b1_q, c1_q, d1_q;
  logic                    f12_q, f21_q;

  // Stage 2 signals.
  logic                    w1, w2, c12, c21, nc;
  logic                    o12a, o21a, o12, o21, do12, do21;
  logic                    v2_q;
  logic [TURN_BITS-1:0]    a2_q, b2_q, c2_q, d2_q;
  logic                    c12_q, c21_q, o12_q, o21_q, do12_q, do21_q;

  // Stage 3 signals.
  logic [TURN_BITS-1:0]    l1_d, l2_d;
  logic [HI_W-1:0]         u1_d, u2_d;
  logic                    v3_q;
  logic [TURN_BITS-1:0]    l1_q, l2_q;
  logic [HI_W-1:0]         u1_q, u2_q;

  // Output stage signals.
  logic [HI_W-1:0]         u1c, u2c;
  logic [HI_W:0]           span1;
  ciu_out_t                res_d;
  logic                    done_q;
  ciu_out_t                res_q;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign dab = $signed({in_i.upper_a[IN_W-1], in_i.upper_a})
             - $signed({in_i.lower_a[IN_W-1], in_i.lower_a});
  assign dcd = $signed({in_i.upper_b[IN_W-1], in_i.upper_b})
             - $signed({in_i.lower_b[IN_W-1], in_i.lower_b});

  always_ff @(posedge clk_i) begin
    a1_q  <= in_i.lower_a[TURN_BITS-1:0];
    b1_q  <= in_i.upper_a[TURN_BITS-1:0];
    c1_q  <= in_i.lower_b[TURN_BITS-1:0];
    d1_q  <= in_i.upper_b[TURN_BITS-1:0];
    f12_q <= (dab >= TurnWide) || (dab <= -TurnWide);
    f21_q <= (dcd >= TurnWide) || (dcd <= -TurnWide);
  end

  // The flags follow the ordered case table; later terms see earlier ones.
  always_comb begin
    w1  = a1_q > b1_q;
    w2  = c1_q > d1_q;
    c12 = f12_q
       || (a1_q <= c1_q && b1_q >= d1_q && !w1 && !w2)
       || (a1_q <= d1_q && a1_q <= c1_q && w1 && !w2)
       || (b1_q >= d1_q && a1_q >= c1_q && w1 && !w2)
       || (a1_q <= c1_q && b1_q >= d1_q && w1 && w2);
    c21 = f21_q
       || (c1_q <= a1_q && d1_q >= b1_q && !w1 && !w2)
       || (a1_q >= c1_q && b1_q >= d1_q && !w1 && w2)
       || (a1_q <= c1_q && b1_q <= d1_q && !w1 && w2)
       || (c1_q <= a1_q && d1_q >= b1_q && w1 && w2);
    nc  = !c12 && !c21;
    o12a = (c1_q < b1_q && d1_q > b1_q && c1_q > a1_q && !w1 && !w2 && nc)
        || (c1_q < b1_q && d1_q > b1_q && d1_q < a1_q && w1 && !w2 && nc);
    o21a = (c1_q < a1_q && d1_q > a1_q && b1_q > d1_q && !w1 && !w2 && nc)
        || (c1_q < a1_q && d1_q > a1_q && c1_q > b1_q && w1 && !w2 && nc)
        || (a1_q < d1_q && b1_q > d1_q && b1_q < c1_q && !w1 && w2 && nc);
    o12 = o12a
       || (a1_q < c1_q && b1_q > c1_q && a1_q > d1_q && !w1 && w2 && nc)
       || (a1_q < c1_q && a1_q > d1_q && w1 && w2 && nc);
    o21 = o21a
       || (c1_q < a1_q && c1_q > b1_q && w1 && w2 && nc);
    do12 = (c1_q < b1_q && a1_q < d1_q && w1 && !w2 && nc && !o12a)
        || (a1_q < c1_q && a1_q <= d1_q && w1 && w2 && nc);
    do21 = (a1_q < d1_q && c1_q < b1_q && !w1 && w2 && nc && !o21a)
        || (c1_q < a1_q && c1_q <= b1_q && w1 && w2 && nc);
  end

  always_ff @(posedge clk_i) begin
    a2_q   <= a1_q;
    b2_q   <= b1_q;
    c2_q   <= c1_q;
    d2_q   <= d1_q;
    c12_q  <= c12;
    c21_q  <= c21;
    o12_q  <= o12;
    o21_q  <= o21;
    do12_q <= do12;
    do21_q <= do21;
  end

  // Priority follows the table: the last matching case wins.
  always_comb begin
    l1_d = a2_q;
    u1_d = HI_W'(b2_q);
    l2_d = c2_q;
    u2_d = HI_W'(d2_q);
    if (do21_q) begin
      l1_d = c2_q;
      u1_d = HI_W'(b2_q) + TURN_HI;
    end else if (do12_q) begin
      l1_d = a2_q;
      u1_d = HI_W'(d2_q) + TURN_HI;
    end else if (o21_q) begin
      l1_d = c2_q;
      u1_d = HI_W'(b2_q);
    end else if (o12_q) begin
      l1_d = a2_q;
      u1_d = HI_W'(d2_q);
    end else if (c21_q) begin
      l1_d = c2_q;
      u1_d = HI_W'(d2_q);
    end
    if (c12_q || c21_q || o12_q || o21_q || do12_q || do21_q) begin
      l2_d = '0;
      u2_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_q <= l1_d;
    u1_q <= u1_d;
    l2_q <= l2_d;
    u2_q <= u2_d;
  end

  always_comb begin
    u1c = (u1_q < HI_W'(l1_q)) ? u1_q + TURN_HI : u1_q;
    u2c = (u2_q < HI_W'(l2_q)) ? u2_q + TURN_HI : u2_q;
    span1 = {1'b0, u1c} - (HI_W + 1)'(l1_q);
    res_d.lower_a_out = l1_q;
    res_d.upper_a_out = u1c;
    res_d.lower_b_out = l2_q;
    res_d.upper_b_out = u2c;
    if (span1 > (HI_W + 1)'(TURN_HI)) begin
      res_d.lower_a_out = '0;
      res_d.upper_a_out = TURN_HI;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= acc;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
